@@ rtl/core/modexp_pkg.sv @@
package modexp_pkg;

  // Width of every operand and result port.
  localparam int FIELD_W = 31;

  // Status of the serial multiplier as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

@@ rtl/core/modexp_mulmod.sv @@
module modexp_mulmod #(
  parameter int N = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [N-1:0]        x,
  input  logic [N-1:0]        y,
  input  logic [N-1:0]        m,
  output modexp_pkg::mm_stat_t stat,
  output logic [N-1:0]        product
);
  import modexp_pkg::*;

  localparam int CW = $clog2(N);

  logic [N-1:0]  x_r, x_nxt;
  logic [N-1:0]  y_r, y_nxt;
  logic [N-1:0]  m_r, m_nxt;
  logic [N-1:0]  acc_r, acc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [N:0]    dbl;
  logic [N:0]    red1_w;
  logic [N:0]    sum;
  logic [N:0]    red2_w;

  // One multiplier bit a cycle, most significant first: double, reduce, add, reduce.
  // The running value stays below m, and y is below m, so one subtraction
  // after each step is enough.
  always_comb begin
    dbl    = {acc_r, 1'b0};
    red1_w = (dbl >= {1'b0, m_r}) ? (dbl - {1'b0, m_r}) : dbl;
    sum    = {1'b0, red1_w[N-1:0]} + {1'b0, (x_r[N-1] ? y_r : {N{1'b0}})};
    red2_w = (sum >= {1'b0, m_r}) ? (sum - {1'b0, m_r}) : sum;
  end

  // Next-state logic of the multiplier.
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    m_nxt    = m_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = x;
      y_nxt    = y;
      m_nxt    = m;
      acc_nxt  = '0;
      cnt_nxt  = CW'(N - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = red2_w[N-1:0];
      x_nxt   = {x_r[N-2:0], 1'b0};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    m_r   <= m_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = acc_r;

endmodule

@@ rtl/core/modular_exponentiation.sv @@
// Modular exponentiation: result = base ^ exponent mod modulus.
// Input channel in_valid/in_ready carries base, exponent and modulus; the
// result channel out_valid/out_ready carries result. Only the low
// OPERAND_BITS bits of each input field are used. A zero exponent gives 1
// for any modulus; a zero modulus with a nonzero exponent gives 0.
// The block works on one request at a time. The base is first reduced by the
// modulus, then every exponent bit from the top down costs one squaring and,
// for a set bit, one multiplication by the reduced base. Each of these runs
// on a bit-serial multiply-and-reduce unit. A zero exponent or zero modulus
// skips the multiplier and goes straight to the final state. in_ready is high
// only while the block is idle. The result sits in an output register; if the
// receiver stalls, the finished result waits there. One further request is
// still accepted and worked on, but its result then waits in the sequencer
// with in_ready low until the held result has left.
// Reset (rst_n low, synchronous) returns the block to idle with no result.
module modular_exponentiation #(
  parameter int OPERAND_BITS = 31
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [modexp_pkg::FIELD_W-1:0]  in_base,
  input  logic [modexp_pkg::FIELD_W-1:0]  in_exponent,
  input  logic [modexp_pkg::FIELD_W-1:0]  in_modulus,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [modexp_pkg::FIELD_W-1:0]  out_result
);
  import modexp_pkg::*;

  localparam int N  = OPERAND_BITS;
  localparam int BW = $clog2(N);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [N-1:0]       base_r, base_nxt;
  logic [N-1:0]       exp_r, exp_nxt;
  logic [N-1:0]       mod_r, mod_nxt;
  logic [N-1:0]       acc_r, acc_nxt;
  logic [BW-1:0]      bit_r, bit_nxt;
  logic               start_r, start_nxt;
  logic [FIELD_W-1:0] out_result_r, out_result_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [N-1:0]       mm_x;
  logic [N-1:0]       mm_y;
  logic [N-1:0]       mm_prod;
  mm_stat_t           mm_st;
  logic [N-1:0]       one_m;
  logic [N-1:0]       in_b;
  logic [N-1:0]       in_e;
  logic [N-1:0]       in_m;

  assign in_b  = in_base[N-1:0];
  assign in_e  = in_exponent[N-1:0];
  assign in_m  = in_modulus[N-1:0];
  assign one_m = (mod_r == N'(1)) ? '0 : N'(1);

  // Operand selection for the serial multiplier.
  always_comb begin
    unique case (state_r)
      S_RED: begin
        mm_x = base_r;
        mm_y = one_m;
      end
      S_SQ: begin
        mm_x = acc_r;
        mm_y = acc_r;
      end
      default: begin
        mm_x = acc_r;
        mm_y = base_r;
      end
    endcase
  end

  modexp_mulmod #(
    .N(N)
  ) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start_r),
    .x       (mm_x),
    .y       (mm_y),
    .m       (mod_r),
    .stat    (mm_st),
    .product (mm_prod)
  );

  // Sequencer over the exponent bits.
  always_comb begin
    state_nxt      = state_r;
    base_nxt       = base_r;
    exp_nxt        = exp_r;
    mod_nxt        = mod_r;
    acc_nxt        = acc_r;
    bit_nxt        = bit_r;
    start_nxt      = 1'b0;
    out_result_nxt = out_result_r;
    out_valid_nxt  = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r) inside
      S_IDLE: begin
        if (in_valid) begin
          base_nxt = in_b;
          exp_nxt  = in_e;
          mod_nxt  = in_m;
          if (in_e == '0) begin
            acc_nxt   = N'(1);
            state_nxt = S_FIN;
          end else if (in_m == '0) begin
            acc_nxt   = '0;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_RED;
            start_nxt = 1'b1;
          end
        end
      end
      S_RED: begin
        if (mm_st.done) begin
          base_nxt  = mm_prod;
          acc_nxt   = one_m;
          bit_nxt   = BW'(N - 1);
          state_nxt = S_SQ;
          start_nxt = 1'b1;
        end
      end
      S_SQ, S_MUL: begin
        if (mm_st.done) begin
          acc_nxt = mm_prod;
          if (state_r == S_SQ && exp_r[N-1]) begin
            state_nxt = S_MUL;
            start_nxt = 1'b1;
          end else if (bit_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            bit_nxt   = bit_r - 1'b1;
            exp_nxt   = {exp_r[N-2:0], 1'b0};
            state_nxt = S_SQ;
            start_nxt = 1'b1;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_result_nxt = FIELD_W'(acc_r);
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    exp_r        <= exp_nxt;
    mod_r        <= mod_nxt;
    acc_r        <= acc_nxt;
    bit_r        <= bit_nxt;
    out_result_r <= out_result_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

`ifndef SYNTHESIS
  // The multiplier is never left running while a new request can come in.
  a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !mm_st.busy && !start_r)
    else $error("multiplier busy while block idle");

  // A finished product only arrives in a state that waits for one.
  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    mm_st.done |-> (state_r == S_RED || state_r == S_SQ || state_r == S_MUL))
    else $error("multiplier result outside a calculation state");

  // Every product is fully reduced by the modulus.
  a_prod_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    mm_st.done |-> (mm_prod < mod_r))
    else $error("product not reduced below modulus");

  // A start is always followed by the unit running.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |=> mm_st.busy)
    else $error("multiplier did not start");
`endif

endmodule

@@ sim/modular_exponentiation_tb.sv @@
`timescale 1ns / 100ps

module modular_exponentiation_tb;
  import modexp_pkg::*;

  localparam int OPERAND_BITS = 31;
  localparam int CLK_HALF     = 6;
  localparam int CYCLE_LIMIT  = 3_000_000;
  // Covers the worst case for one request, with every exponent bit set, plus overhead.
  localparam int DRAIN_CYCLES = 2100;
  localparam int HOLD_OFF_CYCLES = 5000;

  typedef logic [FIELD_W-1:0] field_t;

  localparam field_t FIELD_MAX    = '1;
  localparam field_t OPERAND_MASK = field_t'((64'd1 << OPERAND_BITS) - 64'd1);

  typedef struct {
    field_t base;
    field_t exponent;
    field_t modulus;
    field_t result;
  } power_req_t;

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   in_valid  = 1'b0;
  field_t in_base     = '0;
  field_t in_exponent = '0;
  field_t in_modulus  = '0;
  logic   out_ready = 1'b0;
  logic   in_ready;
  logic   out_valid;
  field_t out_result;

  power_req_t expected_powers[$];
  int unsigned cycle_cnt     = 0;
  int unsigned err_count     = 0;
  int unsigned sent_count    = 0;
  int unsigned checked_count = 0;
  bit          hold_off_req  = 1'b0;
  bit          calm          = 1'b0;

  modular_exponentiation #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_base     (in_base),
    .in_exponent (in_exponent),
    .in_modulus  (in_modulus),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_result  (out_result)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Square-and-multiply over every operand bit, reducing each product at once.
  function automatic field_t mod_power(field_t b, field_t e, field_t m);
    logic [63:0] mod_w;
    logic [63:0] red_base;
    logic [63:0] acc;
    b = b & OPERAND_MASK;
    e = e & OPERAND_MASK;
    m = m & OPERAND_MASK;
    if (e == '0) return field_t'(1);
    if (m == '0) return '0;
    mod_w    = {{(64 - FIELD_W){1'b0}}, m};
    red_base = {{(64 - FIELD_W){1'b0}}, b} % mod_w;
    acc      = (mod_w == 64'd1) ? 64'd0 : 64'd1;
    for (int i = OPERAND_BITS - 1; i >= 0; i--) begin
      acc = (acc * acc) % mod_w;
      if (e[i]) acc = (acc * red_base) % mod_w;
    end
    return field_t'(acc);
  endfunction

  // Mostly short gaps, now and then a long one; none at all in calm stretches.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  // Operand values with a bias towards edges and awkward bit patterns.
  function automatic field_t rand_operand();
    field_t v;
    v = field_t'($urandom());
    case ($urandom_range(0, 6))
      0: v = field_t'($urandom_range(0, 255));
      1: v = FIELD_MAX - field_t'($urandom_range(0, 255));
      2: v = field_t'(1) << $urandom_range(0, FIELD_W - 1);
      3: v = FIELD_MAX >> $urandom_range(0, FIELD_W - 1);
      4: v = v & field_t'($urandom());
      default: ;
    endcase
    return v;
  endfunction

  function automatic field_t rand_modulus();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return '0;
    if (r < 5) return field_t'(1);
    if (r < 20) return field_t'($urandom_range(2, 1000));
    return rand_operand();
  endfunction

  // Offer one request, hold it until taken, then idle for a random gap.
  task automatic send_request(field_t b, field_t e, field_t m);
    power_req_t req;
    int unsigned gap;
    @(negedge clk);
    in_valid    <= 1'b1;
    in_base     <= b;
    in_exponent <= e;
    in_modulus  <= m;
    do @(posedge clk); while (!in_ready);
    req.base     = b;
    req.exponent = e;
    req.modulus  = m;
    req.result   = mod_power(b, e, m);
    expected_powers.insert(expected_powers.size(), req);
    sent_count++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Receiver: random stalls, plus a long forced hold-off when one is requested.
  initial begin
    int unsigned stall_left;
    int unsigned hold_off_left;
    bit          hold_off_taken;
    stall_left     = 0;
    hold_off_left  = 0;
    hold_off_taken = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_taken) begin
        hold_off_taken = 1'b1;
        hold_off_left  = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
        out_ready <= 1'b0;
        hold_off_left--;
      end else if (stall_left > 0 && !calm) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready  <= 1'b1;
        stall_left = 0;
        if ($urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
    end
  end

  // Compare each delivered result with the oldest outstanding request.
  always @(posedge clk) begin
    power_req_t req;
    if (rst_n && out_valid && out_ready) begin
      if (expected_powers.size() == 0) begin
        $error("out_result: unexpected result %0d with no request outstanding", out_result);
        err_count++;
      end else begin
        req = expected_powers.pop_front();
        checked_count++;
        if (out_result !== req.result) begin
          $error("out_result mismatch: expected %0d, actual %0d (base %0d exp %0d mod %0d)",
                 req.result, out_result, req.base, req.exponent, req.modulus);
          err_count++;
        end
      end
    end
  end

  // Edges of the operand ranges and every special case of the arithmetic.
  task automatic test_corner_cases();
    send_request('0, '0, field_t'(1));
    send_request('0, '0, '0);                       // zero exponent, zero modulus
    send_request(field_t'(5), field_t'(3), '0);     // zero modulus, nonzero exponent
    send_request(field_t'(7), '0, field_t'(1));     // zero exponent wins over modulus one
    send_request(field_t'(7), field_t'(5), field_t'(1));
    send_request('0, field_t'(5), field_t'(13));    // zero base
    send_request(FIELD_MAX, FIELD_MAX, FIELD_MAX);
    send_request(FIELD_MAX, FIELD_MAX, FIELD_MAX - 1);
    send_request(field_t'(2), field_t'(10), field_t'(1000));
    send_request(field_t'(3), field_t'(1), field_t'(7));
    send_request(FIELD_MAX, field_t'(1), field_t'(2));
    send_request(field_t'(1), FIELD_MAX, FIELD_MAX);
    send_request(field_t'(2), FIELD_MAX, FIELD_MAX);
    send_request(field_t'(100), field_t'(3), field_t'(7));   // base above modulus
    send_request(field_t'(13), field_t'(5), field_t'(13));   // base equal to modulus
    send_request(FIELD_MAX, field_t'(2), field_t'(1));
    send_request(field_t'(3), field_t'(1) << (FIELD_W - 1), field_t'(1000003));
    send_request(field_t'(2), field_t'(30), FIELD_MAX);
    send_request(FIELD_MAX - 1, field_t'(2), FIELD_MAX);
    send_request(field_t'(12345), FIELD_MAX, field_t'(1) << (FIELD_W - 1));
    send_request(FIELD_MAX, '0, '0);
    send_request('0, FIELD_MAX, '0);
  endtask

  task automatic test_random_operands(int unsigned count);
    repeat (count) send_request(rand_operand(), rand_operand(), rand_modulus());
  endtask

  // No idling on either side, so requests and results follow each other closely.
  task automatic test_back_to_back(int unsigned count);
    calm = 1'b1;
    repeat (count) send_request(rand_operand(), rand_operand(), rand_modulus());
    calm = 1'b0;
  endtask

  // The receiver stops for longer than one request takes, so the block stalls its input.
  task automatic test_output_hold_off(int unsigned count);
    hold_off_req = 1'b1;
    repeat (count) send_request(rand_operand(), rand_operand(), rand_modulus());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_corner_cases();
    test_random_operands(250);
    test_back_to_back(12);
    test_output_hold_off(5);

    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_powers.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d results, including zero exponents,",
             sent_count, checked_count);
    $display("zero and unit moduli, full-width operands and a long output stall.");
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
